[src/osbt_pkg.sv]
// shared types and constants of the object start boundary table
// no dependencies

package osbt_pkg;

    localparam int CUR_W   = 13;   // cursor_card and query_card
    localparam int START_W = 19;   // object_start
    localparam int END_W   = 20;   // object_end
    localparam int NEXT_W  = 14;   // next_cursor
    localparam int FIRST_W = 19;   // first_object
    localparam int ENTRY_W = 8;    // one signed byte per card
    localparam int EXP_W   = 5;    // skip exponent, at most log2 of the card count

    localparam logic [ENTRY_W-1:0] DIST_MAX = 8'd127;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RCHK  = 6'b000010,
        S_RFILL = 6'b000100,
        S_QMOD  = 6'b001000,
        S_QRD   = 6'b010000,
        S_QEV   = 6'b100000
    } t_state;

endpackage

[src/osbt_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies

module osbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/object_start_boundary_table.sv]
// object start boundary table: top level, sequencer around the card table ram
// depends on osbt_pkg and osbt_ram
//
// usage
//   one command word is taken at a rising edge where start is high and busy
//   is low. i_command selects a record (object spans cards) or a query (find
//   the start of the object covering a card).
//   each word gives exactly one result word, shown for one cycle with o_valid
//   high; the receiver cannot stall and must take it in that cycle.
//   busy drops in the cycle the result is shown, so the next word may be
//   issued there.
// sequence
//   record: S_RCHK writes the first card the object crosses, then S_RFILL
//     writes the others, one table byte per cycle; the ram write port sets the pace
//   query: S_QRD, then S_QEV, repeated for each skip hop walked back (at most log2
//     of the card count); each hop waits for one registered ram read. a query card
//     at or above the card count adds a S_QMOD reduction by reciprocal multiply
// reset
//   i_rst_n low (sampled on i_clk) returns the sequencer to idle and drops
//   o_valid; the table itself is not cleared, entries hold garbage until a
//   record writes them
// hazards
//   one word is in flight at a time and all writes of a record finish before
//   its result, so a later query never reads an entry with a write pending

module object_start_boundary_table
    import osbt_pkg::*;
#(
    parameter int CARD_COUNT = 8192,
    parameter int CARD_UNITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  logic [CUR_W-1:0]   i_cursor_card,
    input  logic [START_W-1:0] i_object_start,
    input  logic [END_W-1:0]   i_object_end,
    input  logic [CUR_W-1:0]   i_query_card,
    output logic               o_valid,
    output logic [NEXT_W-1:0]  o_next_cursor,
    output logic [FIRST_W-1:0] o_first_object
);

    localparam int CW = $clog2(CARD_COUNT);                     // card index width
    localparam int AW = $clog2(CARD_COUNT * CARD_UNITS + 1);    // boundary offset width
    localparam int XW = (AW > END_W) ? AW : END_W;              // offset compare width
    // query card reduction: exact quotient by reciprocal for any card below 2^CUR_W
    localparam int     QS = CUR_W + CW;
    localparam longint QM = ((longint'(1) << QS) + longint'(CARD_COUNT) - 1)
                            / longint'(CARD_COUNT);
    localparam int     PW = 2 * CUR_W + 2;                      // reciprocal product width

    t_state             r_state, n_state;
    logic               r_cmd, n_cmd;
    logic [CUR_W-1:0]   r_cur, n_cur;
    logic [START_W-1:0] r_st, n_st;
    logic [END_W-1:0]   r_en, n_en;
    logic [CUR_W-1:0]   r_q, n_q;
    logic [CW:0]        r_card, n_card;     // one bit more to hold the card count
    logic [AW-1:0]      r_addr, n_addr;     // boundary offset of r_card
    logic [EXP_W-1:0]   r_exp, n_exp;
    logic [CW:0]        r_left, n_left;     // cards left in the current skip group
    logic [CW:0]        r_grp, n_grp;       // size of the current skip group
    logic               r_valid, n_valid;
    logic [NEXT_W-1:0]  r_next, n_next;
    logic [FIRST_W-1:0] r_first, n_first;

    logic               mem_we;
    logic [CW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata;

    logic [AW-1:0]      addr0;      // boundary of the first crossed card
    logic [XW-1:0]      start_gap;
    logic [AW-1:0]      base;       // boundary of the card being looked at
    logic [ENTRY_W-1:0] skip_e;
    logic [CW:0]        skip_step;
    logic [PW-1:0]      q_prod;
    logic [CUR_W-1:0]   q_quot;
    logic [CUR_W-1:0]   q_red;

    logic accept;
    assign accept = start && !busy;

    osbt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CARD_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (n_card[CW-1:0]),
        .o_rdata (mem_rdata)
    );

    // datapath terms
    assign addr0     = AW'(r_cur) * AW'(CARD_UNITS);
    assign start_gap = XW'(addr0) - XW'(r_st);
    assign base      = AW'(r_card[CW-1:0]) * AW'(CARD_UNITS);
    assign skip_e    = ~mem_rdata;      // code -k means exponent k-1
    assign skip_step = (CW+1)'(1) << skip_e;
    assign q_prod    = PW'(r_q) * PW'(QM);
    assign q_quot    = CUR_W'(q_prod >> QS);
    assign q_red     = r_q - CUR_W'(PW'(q_quot) * PW'(CARD_COUNT));

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_cur     = r_cur;
        n_st      = r_st;
        n_en      = r_en;
        n_q       = r_q;
        n_card    = r_card;
        n_addr    = r_addr;
        n_exp     = r_exp;
        n_left    = r_left;
        n_grp     = r_grp;
        n_valid   = 1'b0;
        n_next    = r_next;
        n_first   = r_first;
        mem_we    = 1'b0;
        mem_waddr = r_card[CW-1:0];
        mem_wdata = ~(ENTRY_W'(r_exp));

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd = i_command;
                    n_cur = i_cursor_card;
                    n_st  = i_object_start;
                    n_en  = i_object_end;
                    n_q   = i_query_card;
                    if (i_command == CMD_RECORD) begin
                        n_state = S_RCHK;
                    end else if (int'(i_query_card) >= CARD_COUNT) begin
                        n_state = S_QMOD;
                    end else begin
                        n_card  = (CW+1)'(i_query_card);
                        n_state = S_QRD;
                    end
                end
            end

            // first crossed card: store distance to the object start, or end if none
            S_RCHK: begin
                if (int'(r_cur) >= CARD_COUNT) begin
                    n_valid = 1'b1;
                    n_next  = NEXT_W'(CARD_COUNT);
                    n_first = '0;
                    n_state = S_IDLE;
                end else if (XW'(addr0) < XW'(r_st) || XW'(addr0) >= XW'(r_en)) begin
                    n_valid = 1'b1;
                    n_next  = NEXT_W'(r_cur);
                    n_first = '0;
                    n_state = S_IDLE;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = CW'(r_cur);
                    mem_wdata = (start_gap > XW'(DIST_MAX)) ? DIST_MAX : ENTRY_W'(start_gap);
                    n_card    = (CW+1)'(r_cur) + 1'b1;
                    n_addr    = addr0 + AW'(CARD_UNITS);
                    n_exp     = '0;
                    n_left    = (CW+1)'(1);
                    n_grp     = (CW+1)'(1);
                    n_state   = S_RFILL;
                end
            end

            // following cards: skip codes in groups of 1, 2, 4, ...
            S_RFILL: begin
                if (int'(r_card) < CARD_COUNT && XW'(r_addr) < XW'(r_en)) begin
                    mem_we = 1'b1;
                    n_card = r_card + 1'b1;
                    n_addr = r_addr + AW'(CARD_UNITS);
                    if (r_left == (CW+1)'(1)) begin
                        n_exp  = r_exp + 1'b1;
                        n_grp  = r_grp << 1;
                        n_left = r_grp << 1;
                    end else begin
                        n_left = r_left - 1'b1;
                    end
                end else begin
                    n_valid = 1'b1;
                    n_next  = NEXT_W'(r_card);
                    n_first = '0;
                    n_state = S_IDLE;
                end
            end

            // query card modulo card count in one step
            S_QMOD: begin
                n_card  = (CW+1)'(q_red);
                n_state = S_QRD;
            end

            S_QRD: begin
                n_state = S_QEV;
            end

            // entry of r_card is on the read port; hop back or finish
            S_QEV: begin
                if (!mem_rdata[ENTRY_W-1]) begin
                    n_valid = 1'b1;
                    n_next  = '0;
                    n_first = (XW'(mem_rdata) > XW'(base)) ? '0
                                                            : FIRST_W'(base - AW'(mem_rdata));
                    n_state = S_IDLE;
                end else if (int'(skip_e) >= CW || skip_step > r_card) begin
                    // walk would leave the table below card zero
                    n_valid = 1'b1;
                    n_next  = '0;
                    n_first = '0;
                    n_state = S_IDLE;
                end else begin
                    n_card = r_card - skip_step;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_cmd   <= n_cmd;
        r_cur   <= n_cur;
        r_st    <= n_st;
        r_en    <= n_en;
        r_q     <= n_q;
        r_card  <= n_card;
        r_addr  <= n_addr;
        r_exp   <= n_exp;
        r_left  <= n_left;
        r_grp   <= n_grp;
        r_next  <= n_next;
        r_first <= n_first;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_next_cursor  = r_next;
    assign o_first_object = r_first;

    // table is written only while a record runs
    a_we_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_RCHK || r_state == S_RFILL) && r_cmd == CMD_RECORD)
        else $error("table write outside a record");

    // a result is shown only once the sequencer is back to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // an accepted word always occupies the sequencer next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy && !o_valid)
        else $error("accepted word did not start");

    // query results carry no cursor, record results no start offset
    a_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_cmd == CMD_QUERY) ? (o_next_cursor == '0) : (o_first_object == '0))
        else $error("unused result field not zero");

    // the query walk stays inside the table
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QEV) |-> int'(r_card) < CARD_COUNT)
        else $error("query walk left the table");

endmodule
